>>> sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/fcr_pkg.sv
`timescale 1ns / 1ps

package fcr_pkg;

    // Delay memory geometry; depth is always a power of two.
    localparam int ADDR_BITS   = 17;
    localparam int DELAY_DEPTH = 1 << ADDR_BITS;

    // Sample and coefficient formats
    localparam int SAMPLE_BITS = 16;
    localparam int GAIN_BITS   = 15;
    localparam int DELAY_BITS  = 17;
    localparam int FRAC_BITS   = 15;
    localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);

    // Exact product of a sample and a zero-extended gain, plus headroom for sums
    localparam int PROD_BITS    = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int ACC_BITS     = PROD_BITS + 2;
    localparam int DL_WIDE_BITS = (ADDR_BITS > DELAY_BITS) ? ADDR_BITS : DELAY_BITS;

    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    // Configuration port
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = DELAY_BITS;

    typedef logic [ADDR_BITS-1:0]          addr_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic [GAIN_BITS-1:0]          gain_t;
    typedef logic [CFG_IDX_BITS-1:0]       reg_idx_t;

    // Register indexes
    localparam reg_idx_t REG_DELAY_LENGTH = reg_idx_t'(0);
    localparam reg_idx_t REG_DECAY_COEFF  = reg_idx_t'(1);
    localparam reg_idx_t REG_DRY_GAIN     = reg_idx_t'(2);
    localparam reg_idx_t REG_WET_GAIN     = reg_idx_t'(3);

    typedef struct packed {
        logic [DELAY_BITS-1:0] delay_length;
        gain_t                 decay_coeff;
        gain_t                 dry_gain;
        gain_t                 wet_gain;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        delay_length: 17'd4800,
        decay_coeff:  15'd29491,
        dry_gain:     15'd32767,
        wet_gain:     15'd9830
    };

    // Source of the delayed sample for one request
    typedef struct packed {
        logic fwd;     // slot is being written on the same edge as the read
        logic stored;  // slot written since reset; otherwise it reads as zero
    } rd_sel_t;

    // Signed sample times unsigned Q0.15 gain, exact
    function automatic prod_t mul_gain(input sample_t s, input gain_t g);
        prod_t a;
        prod_t b;
        a = prod_t'(s);
        b = prod_t'({1'b0, g});
        return a * b;
    endfunction

    // Q1.30 to Q1.15, round to nearest, ties toward plus infinity
    function automatic acc_t round_q15(input acc_t p);
        acc_t t;
        t = p + acc_t'(ROUND_HALF);
        return t >>> FRAC_BITS;
    endfunction

    // Clamp to the sample range
    function automatic sample_t sat_sample(input acc_t v);
        acc_t hi;
        acc_t lo;
        hi = acc_t'(SAMPLE_MAX);
        lo = acc_t'(SAMPLE_MIN);
        if (v > hi)
        begin
            return sample_t'(hi[SAMPLE_BITS-1:0]);
        end
        else if (v < lo)
        begin
            return sample_t'(lo[SAMPLE_BITS-1:0]);
        end
        return sample_t'(v[SAMPLE_BITS-1:0]);
    endfunction

endpackage

>>> sv/fcr_if.sv
`timescale 1ns / 1ps

// Input sample channel
interface fcr_in_if;
    import fcr_pkg::*;
    logic    valid;
    logic    ready;
    sample_t sample_in;
    logic    block_end;

    modport source (output valid, output sample_in, output block_end, input ready);
    modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

// Output sample channel
interface fcr_out_if;
    import fcr_pkg::*;
    logic    valid;
    logic    ready;
    sample_t sample_out;
    logic    block_end_out;

    modport source (output valid, output sample_out, output block_end_out, input ready);
    modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface

// Register write channel
interface fcr_cfg_if;
    import fcr_pkg::*;
    logic                     valid;
    logic                     ready;
    reg_idx_t                 index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/fcr_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port.
// A read of the address written on the same edge returns the old data.
module fcr_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/fcr_regs.sv
`timescale 1ns / 1ps

// Configuration registers; writes to unknown indexes are dropped.
module fcr_regs (
    input  logic         clk,
    input  logic         rst_n,
    fcr_cfg_if.sink      cfg,
    output fcr_pkg::cfg_t cfg_val
);
    import fcr_pkg::*;

    cfg_t cfg_val_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_val_reg <= CFG_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DELAY_LENGTH: cfg_val_reg.delay_length <= cfg.data[DELAY_BITS-1:0];
                REG_DECAY_COEFF:  cfg_val_reg.decay_coeff  <= cfg.data[GAIN_BITS-1:0];
                REG_DRY_GAIN:     cfg_val_reg.dry_gain     <= cfg.data[GAIN_BITS-1:0];
                REG_WET_GAIN:     cfg_val_reg.wet_gain     <= cfg.data[GAIN_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg_val = cfg_val_reg;

endmodule

>>> sv/fcr_arith.sv
`timescale 1ns / 1ps

// Write-back stage datapath: picks the delayed sample, builds the feedback
// value for the delay memory and the two mix products.
module fcr_arith (
    input  fcr_pkg::cfg_t    cfg_val,
    input  fcr_pkg::sample_t x,
    input  fcr_pkg::sample_t mem_q,
    input  fcr_pkg::rd_sel_t sel,
    input  fcr_pkg::sample_t fwd_data,
    output fcr_pkg::sample_t fb,
    output fcr_pkg::prod_t   dry_prod,
    output fcr_pkg::prod_t   wet_prod
);
    import fcr_pkg::*;

    sample_t d;
    acc_t    decay_rnd;

    // Bypass beats memory; never-written slots read as zero
    always_comb
    begin
        if (sel.fwd)
        begin
            d = fwd_data;
        end
        else if (sel.stored)
        begin
            d = mem_q;
        end
        else
        begin
            d = '0;
        end
    end

    // Feedback: x + round(d * decay), saturated
    assign decay_rnd = round_q15(acc_t'(mul_gain(d, cfg_val.decay_coeff)));
    assign fb        = sat_sample(acc_t'(x) + decay_rnd);

    // Mix products, summed in the next stage
    assign dry_prod = mul_gain(x, cfg_val.dry_gain);
    assign wet_prod = mul_gain(d, cfg_val.wet_gain);

endmodule

>>> sv/feedback_comb_reverb.sv
`timescale 1ns / 1ps

// Channel  Dir  Fields                         Handshake
// din      in   sample_in[15:0], block_end      valid/ready
// dout     out  sample_out[15:0], block_end_out valid/ready
// cfg      in   index[3:0], data[16:0]          valid/ready (ready tied high)
//
// Throughput is one request per cycle while dout is not stalled; an accepted request
// passes through the stage 1, stage 2 and stage 3 registers before its result is on dout.
// The rate is set by the feedback loop: registered delay RAM read, then multiply, round,
// add and saturate in the write-back stage, with a one-deep bypass for a delay of one.
// After reset the delay RAM is not swept: slots not yet written since reset read as zero
// (tracked by the write pointer and a wrap flag), so requests are taken right away.
// Backpressure on dout ripples back stage by stage; empty stages absorb stalls.
module feedback_comb_reverb (
    input  logic     clk,
    input  logic     rst_n,
    fcr_in_if.sink   din,
    fcr_out_if.source dout,
    fcr_cfg_if.sink  cfg
);
    import fcr_pkg::*;

    cfg_t    cfg_val;

    // Write pointer and wrap flag
    addr_t   wp_reg;
    logic    wrapped_reg;

    // Stage 1: RAM data arrives, feedback written back on exit
    logic    s1_valid_reg;
    sample_t s1_x_reg;
    logic    s1_end_reg;
    addr_t   s1_waddr_reg;
    rd_sel_t s1_sel_reg;
    sample_t s1_fwd_data_reg;

    // Stage 2: mix products
    logic    s2_valid_reg;
    logic    s2_end_reg;
    prod_t   s2_dry_reg;
    prod_t   s2_wet_reg;

    // Stage 3: output register
    logic    s3_valid_reg;
    sample_t s3_sample_reg;
    logic    s3_end_reg;

    logic [DL_WIDE_BITS-1:0] dl_wide;
    addr_t   dl;
    addr_t   rd_addr;
    rd_sel_t rd_sel;
    sample_t mem_q;
    sample_t fb;
    prod_t   dry_prod;
    prod_t   wet_prod;
    logic    s3_free;
    logic    s2_free;
    logic    s1_free;
    logic    s1_adv;
    logic    accept;

    fcr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    // Pipeline flow control
    assign s3_free = !s3_valid_reg || dout.ready;
    assign s2_free = !s2_valid_reg || s3_free;
    assign s1_free = !s1_valid_reg || s2_free;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign accept  = din.valid && s1_free;
    assign din.ready = s1_free;

    // Read address: delay taken modulo the RAM depth
    assign dl_wide = DL_WIDE_BITS'(cfg_val.delay_length);
    assign dl      = dl_wide[ADDR_BITS-1:0];
    assign rd_addr = wp_reg - dl;

    // Stage 1 writes on this edge whenever a request is accepted behind it
    assign rd_sel.fwd    = s1_valid_reg && (rd_addr == s1_waddr_reg);
    assign rd_sel.stored = wrapped_reg || (rd_addr < wp_reg);

    fcr_ram #(
        .DEPTH  (DELAY_DEPTH),
        .DATA_W (SAMPLE_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_waddr_reg),
        .wdata (fb),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (mem_q)
    );

    fcr_arith u_arith (
        .cfg_val  (cfg_val),
        .x        (s1_x_reg),
        .mem_q    (mem_q),
        .sel      (s1_sel_reg),
        .fwd_data (s1_fwd_data_reg),
        .fb       (fb),
        .dry_prod (dry_prod),
        .wet_prod (wet_prod)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            wrapped_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg <= wp_reg + addr_t'(1);
                if (&wp_reg)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (s1_free)
            begin
                s1_valid_reg <= din.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1 payload; bypass data is the feedback written on the accept edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg        <= din.sample_in;
            s1_end_reg      <= din.block_end;
            s1_waddr_reg    <= wp_reg;
            s1_sel_reg      <= rd_sel;
            s1_fwd_data_reg <= fb;
        end
    end

    // Stage 2 payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_dry_reg <= dry_prod;
            s2_wet_reg <= wet_prod;
            s2_end_reg <= s1_end_reg;
        end
    end

    // Stage 3: sum, round once, saturate
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_free)
        begin
            s3_sample_reg <= sat_sample(round_q15(acc_t'(s2_dry_reg) + acc_t'(s2_wet_reg)));
            s3_end_reg    <= s2_end_reg;
        end
    end

    assign dout.valid         = s3_valid_reg;
    assign dout.sample_out    = s3_sample_reg;
    assign dout.block_end_out = s3_end_reg;

endmodule

>>> sv/fcr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks for the comb reverb.
module fcr_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input fcr_pkg::sample_t out_sample,
    input logic             out_end
);

    // A stalled result stays offered
    `FCR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "dout.valid dropped while stalled")

    // A stalled result keeps its payload
    `FCR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_sample) && $stable(out_end), "dout payload changed while stalled")

    // An empty output register never backs up the input
    `FCR_ASSERT_NOW(a_in_open, clk, rst_n, !out_valid, in_ready, "din.ready low with empty output")

    // A fresh result follows an earlier accepted request
    `FCR_ASSERT_NOW(a_latency, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 3), "dout.valid rose without matching request")

endmodule

bind feedback_comb_reverb fcr_checker u_fcr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (din.valid),
    .in_ready   (din.ready),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .out_sample (dout.sample_out),
    .out_end    (dout.block_end_out)
);

>>> tb/sv/tb_feedback_comb_reverb.sv
`timescale 1ns / 1ps

module tb_feedback_comb_reverb;
    import fcr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          IDLE_PCT    = 22;
    localparam int          DRAIN_WAIT  = 8;

    // Indexes outside the register map; writes there must be dropped
    localparam reg_idx_t REG_UNMAPPED_LO = reg_idx_t'(4);
    localparam reg_idx_t REG_UNMAPPED_HI = reg_idx_t'(15);

    typedef struct packed {
        sample_t pcm;
        logic    last;
    } frame_t;

    typedef struct packed {
        sample_t mix;
        logic    last;
    } mix_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fcr_in_if  din_if();
    fcr_out_if dout_if();
    fcr_cfg_if cfg_if();

    feedback_comb_reverb u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if),
        .cfg   (cfg_if)
    );

    always #2 clk = ~clk;

    // Shadow of the echo loop
    sample_t                echo_mem [DELAY_DEPTH];
    addr_t                  wr_ptr;
    logic [DELAY_BITS-1:0]  cur_delay;
    gain_t                  cur_decay;
    gain_t                  cur_dry;
    gain_t                  cur_wet;

    frame_t      sample_feed[$];
    mix_result_t mix_expected[$];
    mix_result_t mix_head;

    bit          steady;
    int unsigned err_count;
    int unsigned samples_sent;
    int unsigned mixes_checked;
    int unsigned settings_used;
    int unsigned cycle_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // Q1.30 back to Q1.15: floor((p + half) / 2^15)
    function automatic longint q15_round(input longint p);
        return (p + longint'(ROUND_HALF)) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp_pcm(input longint v);
        if (v > SAMPLE_MAX)
        begin
            return SAMPLE_MAX;
        end
        if (v < SAMPLE_MIN)
        begin
            return SAMPLE_MIN;
        end
        return v;
    endfunction

    // One sample through the comb: read the tap, write back the feedback, queue the mix
    function automatic void comb_step(input sample_t pcm, input logic last);
        longint      x;
        longint      d;
        longint      fb;
        longint      mix;
        addr_t       rd;
        mix_result_t r;
        // depth is 2^ADDR_BITS, so the subtraction wraps; a zero delay reads
        // the slot about to be overwritten
        rd = wr_ptr - addr_t'(cur_delay);
        x = longint'(pcm);
        d = longint'(echo_mem[rd]);
        fb = clamp_pcm(x + q15_round(d * longint'(cur_decay)));
        mix = clamp_pcm(q15_round(x * longint'(cur_dry) + d * longint'(cur_wet)));
        echo_mem[wr_ptr] = sample_t'(fb);
        wr_ptr = wr_ptr + 1'b1;
        r.mix = sample_t'(mix);
        r.last = last;
        mix_expected.insert(mix_expected.size(), r);
    endfunction

    // Sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            din_if.valid <= 1'b0;
        end
        else
        begin
            if (din_if.valid && din_if.ready)
            begin
                comb_step(din_if.sample_in, din_if.block_end);
                samples_sent++;
            end
            if (!din_if.valid || din_if.ready)
            begin
                if (sample_feed.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    din_if.valid     <= 1'b1;
                    din_if.sample_in <= sample_feed[0].pcm;
                    din_if.block_end <= sample_feed[0].last;
                    void'(sample_feed.pop_front());
                end
                else
                begin
                    din_if.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and random backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            dout_if.ready <= 1'b0;
        end
        else
        begin
            if (dout_if.valid && dout_if.ready)
            begin
                if (mix_expected.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected output %0d",
                                              dout_if.sample_out));
                end
                else
                begin
                    mix_head = mix_expected.pop_front();
                    mixes_checked++;
                    if (dout_if.sample_out !== mix_head.mix)
                    begin
                        report_mismatch($sformatf("sample_out %0d, predicted %0d",
                                                  dout_if.sample_out, mix_head.mix));
                    end
                    if (dout_if.block_end_out !== mix_head.last)
                    begin
                        report_mismatch($sformatf("block_end_out %b, predicted %b",
                                                  dout_if.block_end_out, mix_head.last));
                    end
                end
            end
            dout_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d outputs outstanding",
                     cycle_count, mix_expected.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Block until every request went through and every mix came back
    task automatic wait_idle();
        while (sample_feed.size() != 0 || din_if.valid || mix_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // One register write; valid is left high so writes can go back to back
    task automatic set_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_DELAY_LENGTH: cur_delay = val;
            REG_DECAY_COEFF:  cur_decay = val[GAIN_BITS-1:0];
            REG_DRY_GAIN:     cur_dry   = val[GAIN_BITS-1:0];
            REG_WET_GAIN:     cur_wet   = val[GAIN_BITS-1:0];
            default:          ;
        endcase
    endtask

    // Full register set, written only while the pipe is empty
    task automatic apply_setting(input logic [CFG_DATA_BITS-1:0] dl,
                                 input logic [CFG_DATA_BITS-1:0] decay,
                                 input logic [CFG_DATA_BITS-1:0] dry,
                                 input logic [CFG_DATA_BITS-1:0] wet);
        wait_idle();
        set_reg(REG_DELAY_LENGTH, dl);
        set_reg(REG_DECAY_COEFF, decay);
        set_reg(REG_DRY_GAIN, dry);
        // an occasional stray write to an unmapped index must change nothing
        if ($urandom_range(1) == 1)
        begin
            set_reg(reg_idx_t'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                    CFG_DATA_BITS'($urandom));
        end
        set_reg(REG_WET_GAIN, wet);
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    function automatic void queue_sample(input sample_t pcm, input logic last);
        frame_t f;
        f.pcm = pcm;
        f.last = last;
        sample_feed.insert(sample_feed.size(), f);
    endfunction

    // Mostly uniform samples with a bias toward full scale to hit saturation
    function automatic sample_t rand_pcm();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            return sample_t'(SAMPLE_MAX);
        end
        if (pick == 1)
        begin
            return sample_t'(SAMPLE_MIN);
        end
        return sample_t'($urandom);
    endfunction

    task automatic random_run(input int unsigned count);
        repeat (count)
        begin
            queue_sample(rand_pcm(), $urandom_range(15) == 0);
        end
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] rand_gain();
        // upper data bits are random too; only the low gain bits take effect
        return CFG_DATA_BITS'($urandom);
    endfunction

    initial
    begin
        din_if.valid     = 1'b0;
        din_if.sample_in = '0;
        din_if.block_end = 1'b0;
        dout_if.ready    = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_DELAY_LENGTH;
        cfg_if.data      = '0;
        for (int i = 0; i < DELAY_DEPTH; i++)
        begin
            echo_mem[i] = '0;
        end
        wr_ptr    = '0;
        cur_delay = CFG_RESET.delay_length;
        cur_decay = CFG_RESET.decay_coeff;
        cur_dry   = CFG_RESET.dry_gain;
        cur_wet   = CFG_RESET.wet_gain;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: long tap still empty, so only the dry path shows
        queue_sample(sample_t'(SAMPLE_MAX), 1'b0);
        queue_sample(sample_t'(SAMPLE_MIN), 1'b1);
        queue_sample(sample_t'(0), 1'b0);
        queue_sample(sample_t'(1), 1'b0);
        queue_sample(sample_t'(-1), 1'b1);
        queue_sample(sample_t'(16'h5555), 1'b0);
        queue_sample(sample_t'(16'hAAAA), 1'b1);

        // Delay of one with every gain at full scale: feedback saturates
        apply_setting(17'd1, 17'd32767, 17'd32767, 17'd32767);
        repeat (4) queue_sample(sample_t'(SAMPLE_MAX), 1'b0);
        repeat (3) queue_sample(sample_t'(SAMPLE_MIN), 1'b0);
        queue_sample(sample_t'(0), 1'b1);

        // Zero decay and dry, wet written with upper data bits set
        wait_idle();
        set_reg(REG_UNMAPPED_HI, 17'h1FFFF);
        cfg_if.valid <= 1'b0;
        apply_setting(17'd2, 17'd0, 17'd0, 17'h1FFFF);
        queue_sample(sample_t'(SAMPLE_MAX), 1'b0);
        queue_sample(sample_t'(SAMPLE_MIN), 1'b0);
        queue_sample(sample_t'(16'h4000), 1'b0);
        queue_sample(sample_t'(16'hC000), 1'b0);
        queue_sample(sample_t'(-1), 1'b0);
        queue_sample(sample_t'(1), 1'b1);

        // Random phases; the first one runs with no idling on either side
        apply_setting(17'd1, 17'd32767, 17'd32767, 17'd32767);
        steady = 1'b1;
        random_run(150);
        wait_idle();
        steady = 1'b0;

        apply_setting(17'd2, rand_gain(), rand_gain(), rand_gain());
        random_run(150);

        apply_setting(17'd3, rand_gain(), rand_gain(), rand_gain());
        random_run(150);

        apply_setting(CFG_DATA_BITS'($urandom_range(4, 64)), rand_gain(), rand_gain(),
                      rand_gain());
        random_run(200);

        // Zero delay reads the slot about to be overwritten; zero gains
        apply_setting(17'd0, 17'd0, 17'd0, 17'd0);
        random_run(60);

        // Longest delay, taps land on slots far behind the write pointer
        apply_setting(17'h1FFFF, rand_gain(), rand_gain(), rand_gain());
        random_run(60);

        apply_setting(CFG_DATA_BITS'($urandom_range(65, 3000)), rand_gain(), rand_gain(),
                      rand_gain());
        random_run(150);

        apply_setting(CFG_DATA_BITS'($urandom_range(1, 16)), rand_gain(), rand_gain(),
                      rand_gain());
        random_run(250);

        wait_idle();

        $display("%0d samples sent, %0d mixes checked over %0d register settings",
                 samples_sent, mixes_checked, settings_used);
        $display("delays from zero to full range, gains from zero to full scale, %0d cycles",
                 cycle_count);
        if (err_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/fcr_pkg.sv
sv/fcr_if.sv
sv/fcr_ram.sv
sv/fcr_regs.sv
sv/fcr_arith.sv
sv/feedback_comb_reverb.sv
sv/fcr_checker.sv
tb/sv/tb_feedback_comb_reverb.sv
